/* hw/rtl/mcct_pkg.sv */
// Shared definitions for the multi-channel compare timer.
// Action codes, default sizes and the per-channel control bundle.
// No dependencies.
package mcct_pkg;

	// Default sizes for the top-level parameters
	localparam int NumChannelsDef = 4;
	localparam int CountWidthDef  = 16;

	// Fixed field widths of the item ports
	localparam int ActionW   = 2;
	localparam int ChannelW  = 2;
	localparam int DelayW    = 16;
	localparam int RatioW    = 17;
	localparam int PrescaleW = 16;
	localparam int MaskW     = 4;
	localparam int CountOutW = 16;

	// Action codes
	localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
	localparam logic [ActionW-1:0] ACT_START = 2'd1;
	localparam logic [ActionW-1:0] ACT_STOP  = 2'd2;

	// Per-channel control for one processed item
	typedef struct packed {
		logic tick;   // tick item processed
		logic adv;    // shared counter advanced on this tick
		logic start;  // start addressed to this channel
		logic stop;   // stop addressed to this channel
		logic rep;    // repeat mode carried with a start
	} ch_ctrl_t;

endpackage

/* hw/rtl/mcct_prescaler.sv */
// Prescaler and shared free-running counter of the compare timer.
// Holds the clamped ratio, the tick count and the step counter.
// Depends on mcct_pkg.
module mcct_prescaler
	import mcct_pkg::*;
#(
	parameter int COUNT_WIDTH = CountWidthDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [RatioW-1:0]      cfg_wr_data,
	input  logic                   tick,
	output logic                   adv,
	output logic [COUNT_WIDTH-1:0] count_upd
);

	logic [PrescaleW-1:0]   ratio_m1_q;
	logic [PrescaleW-1:0]   pcount_q;
	logic [COUNT_WIDTH-1:0] step_q;

	// Advance when the tick count reaches the ratio minus one
	assign adv       = tick && (pcount_q >= ratio_m1_q);
	assign count_upd = adv ? step_q + COUNT_WIDTH'(1) : step_q;

	// Clamp ratio to 1..65536 and store it minus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_m1_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data == '0) begin
				ratio_m1_q <= '0;
			end else if (cfg_wr_data[RatioW-1]) begin
				ratio_m1_q <= '1;
			end else begin
				ratio_m1_q <= cfg_wr_data[PrescaleW-1:0] - PrescaleW'(1);
			end
		end
	end

	// Count ticks, step the shared counter on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			step_q   <= '0;
		end else if (tick) begin
			if (adv) begin
				pcount_q <= '0;
			end else begin
				pcount_q <= pcount_q + PrescaleW'(1);
			end
			step_q <= count_upd;
		end
	end

endmodule

/* hw/rtl/mcct_channel.sv */
// One compare channel: compare and period registers, mode and flags.
// Decides fire, re-arm and disable for each processed item.
// Depends on mcct_pkg.
module mcct_channel
	import mcct_pkg::*;
#(
	parameter int COUNT_WIDTH = CountWidthDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ch_ctrl_t               ctrl,
	input  logic [COUNT_WIDTH-1:0] count_upd,
	input  logic [COUNT_WIDTH-1:0] period_new,
	output logic                   fire,
	output logic                   enabled_nxt
);

	logic [COUNT_WIDTH-1:0] compare_q;
	logic [COUNT_WIDTH-1:0] period_q;
	logic                   repeat_q;
	logic                   enabled_q;
	logic                   pending_q;
	logic                   pend_a;

	// Match on the new count sets pending, even while disabled
	assign pend_a = pending_q || (ctrl.adv && (compare_q == count_upd));
	assign fire   = ctrl.tick && enabled_q && pend_a;

	// Enable state after this item, for the active mask
	always_comb begin
		enabled_nxt = enabled_q;
		if (ctrl.start) begin
			enabled_nxt = 1'b1;
		end else if (ctrl.stop) begin
			enabled_nxt = 1'b0;
		end else if (fire && !repeat_q) begin
			enabled_nxt = 1'b0;
		end
	end

	// Update channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_q <= '0;
			period_q  <= '0;
			repeat_q  <= 1'b0;
			enabled_q <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			enabled_q <= enabled_nxt;
			if (ctrl.start) begin
				period_q  <= period_new;
				repeat_q  <= ctrl.rep;
				compare_q <= count_upd + period_new;
				pending_q <= (period_new == '0);
			end else if (fire) begin
				// re-arm a repeating channel from the current count
				if (repeat_q) begin
					compare_q <= count_upd + period_q;
					pending_q <= (period_q == '0);
				end else begin
					pending_q <= 1'b0;
				end
			end else if (ctrl.tick) begin
				pending_q <= pend_a;
			end
		end
	end

endmodule

/* hw/rtl/multi_channel_compare_timer.sv */
// Multi-channel compare timer, top level.
// An item taken into the input register is worked from there; its result is loaded into
// the result register once that register is empty or read. Throughput: 1 item per cycle
// while out_ready holds; channel and counter state settle in the one stage between.
// Reset (arst_n low): all channels disabled, flags and counters zero, ratio 1, no result held.
// Depends on mcct_pkg, mcct_prescaler, mcct_channel.
module multi_channel_compare_timer
	import mcct_pkg::*;
#(
	parameter int NUM_CHANNELS = NumChannelsDef,
	parameter int COUNT_WIDTH  = CountWidthDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [RatioW-1:0]    cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ActionW-1:0]   action,
	input  logic [ChannelW-1:0]  channel,
	input  logic [DelayW-1:0]    delay,
	input  logic                 in_ms,
	input  logic                 repeat_mode,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MaskW-1:0]     fire_mask,
	output logic [MaskW-1:0]     active_mask,
	output logic [CountOutW-1:0] count_now
);

	logic                    valid_s1;
	logic [ActionW-1:0]      action_s1;
	logic [ChannelW-1:0]     channel_s1;
	logic [DelayW-1:0]       delay_s1;
	logic                    in_ms_s1;
	logic                    repeat_s1;
	logic                    out_valid_q;
	logic                    advance;
	logic                    go;
	logic                    adv;
	logic [COUNT_WIDTH-1:0]  count_upd;
	logic [DelayW-1:0]       delay_eff;
	logic [DelayW:0]         delay_p1;
	logic [COUNT_WIDTH-1:0]  period_new;
	logic [NUM_CHANNELS-1:0] fire_vec;
	logic [NUM_CHANNELS-1:0] enabled_vec;
	logic [MaskW-1:0]        fire_out;
	logic [MaskW-1:0]        active_out;
	logic [CountOutW-1:0]    count_out;

	// Result register drains or is empty: the stage may move
	assign advance   = !out_valid_q || out_ready;
	assign go        = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	// Hold the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1  <= action;
			channel_s1 <= channel;
			delay_s1   <= delay;
			in_ms_s1   <= in_ms;
			repeat_s1  <= repeat_mode;
		end
	end

	// Period is delay plus one, milliseconds scaled by four first
	assign delay_eff = in_ms_s1 ? {delay_s1[DelayW-3:0], 2'b00} : delay_s1;
	assign delay_p1  = {1'b0, delay_eff} + (DelayW + 1)'(1);

	generate
		if (COUNT_WIDTH > DelayW) begin : g_per_ext
			assign period_new = {{(COUNT_WIDTH - DelayW - 1){1'b0}}, delay_p1};
		end else begin : g_per_trunc
			assign period_new = delay_p1[COUNT_WIDTH-1:0];
		end
	endgenerate

	mcct_prescaler #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_prescaler (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.tick       (go && (action_s1 == ACT_TICK)),
		.adv        (adv),
		.count_upd  (count_upd)
	);

	// One channel per compare unit
	generate
		for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
			ch_ctrl_t ctrl;
			logic     sel;

			assign sel        = (32'(channel_s1) == i);
			assign ctrl.tick  = go && (action_s1 == ACT_TICK);
			assign ctrl.adv   = adv;
			assign ctrl.start = go && (action_s1 == ACT_START) && sel;
			assign ctrl.stop  = go && (action_s1 == ACT_STOP) && sel;
			assign ctrl.rep   = repeat_s1;

			mcct_channel #(
				.COUNT_WIDTH(COUNT_WIDTH)
			) u_channel (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.count_upd  (count_upd),
				.period_new (period_new),
				.fire       (fire_vec[i]),
				.enabled_nxt(enabled_vec[i])
			);
		end
	endgenerate

	// Fit masks and count to the result field widths
	generate
		if (NUM_CHANNELS >= MaskW) begin : g_mask_trunc
			assign fire_out   = fire_vec[MaskW-1:0];
			assign active_out = enabled_vec[MaskW-1:0];
		end else begin : g_mask_ext
			assign fire_out   = {{(MaskW - NUM_CHANNELS){1'b0}}, fire_vec};
			assign active_out = {{(MaskW - NUM_CHANNELS){1'b0}}, enabled_vec};
		end
		if (COUNT_WIDTH >= CountOutW) begin : g_cnt_trunc
			assign count_out = count_upd[CountOutW-1:0];
		end else begin : g_cnt_ext
			assign count_out = {{(CountOutW - COUNT_WIDTH){1'b0}}, count_upd};
		end
	endgenerate

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			fire_mask   <= fire_out;
			active_mask <= active_out;
			count_now   <= count_out;
		end
	end

endmodule

/* sim/timer_checker.sv */
// Checker for the multi-channel compare timer: tracks the prescale ratio, predicts each
// result from the accepted timer operations and compares the returned results in order.
// Depends on mcct_pkg.
`timescale 1ns / 100ps

module timer_checker
	import mcct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [RatioW-1:0]    cfg_wr_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [ActionW-1:0]   action,
	input  logic [ChannelW-1:0]  channel,
	input  logic [DelayW-1:0]    delay,
	input  logic                 in_ms,
	input  logic                 repeat_mode,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [MaskW-1:0]     fire_mask,
	input  logic [MaskW-1:0]     active_mask,
	input  logic [CountOutW-1:0] count_now,
	output int                   fail_cnt,
	output int                   outstanding,
	output int                   checked_cnt,
	output int                   fired_cnt
);

	localparam int NCH = NumChannelsDef;
	localparam int CW  = CountWidthDef;
	localparam logic [RatioW-1:0] RATIO_CAP = 17'h10000;
	localparam int REPORT_MAX = 30;

	typedef struct packed {
		logic [MaskW-1:0]     fire;
		logic [MaskW-1:0]     active;
		logic [CountOutW-1:0] count;
	} timer_result_t;

	// Shadow copy of the timer state
	logic [RatioW-1:0]    ratio_reg;
	logic [PrescaleW-1:0] presc_cnt;
	logic [CW-1:0]        step_cnt;
	logic [CW-1:0]        cmp_val [NCH];
	logic [CW-1:0]        per_val [NCH];
	logic [NCH-1:0]       rep_flag;
	logic [NCH-1:0]       en_flag;
	logic [NCH-1:0]       pend_flag;

	timer_result_t due_results[$];
	int n_fail    = 0;
	int n_checked = 0;
	int n_fired   = 0;

	// Apply one timer operation to the shadow state and return the result it yields
	function automatic timer_result_t step_timer(input logic [ActionW-1:0] act,
			input logic [ChannelW-1:0] ch, input logic [DelayW-1:0] dly,
			input logic ms, input logic rp);
		timer_result_t        res;
		logic [RatioW-1:0]    ratio;
		logic [DelayW-1:0]    ticks;
		logic [MaskW-1:0]     fired;
		int                   i;
		fired = '0;
		case (act)
			ACT_TICK: begin
				ratio = ratio_reg;
				if (ratio == '0)
					ratio = RatioW'(1);
				if (ratio > RATIO_CAP)
					ratio = RATIO_CAP;
				// advance the shared counter once the prescaler reaches the ratio
				if ({1'b0, presc_cnt} >= ratio - RatioW'(1)) begin
					presc_cnt = '0;
					step_cnt  = step_cnt + 1'b1;
					for (i = 0; i < NCH; i++)
						if (cmp_val[i] == step_cnt)
							pend_flag[i] = 1'b1;
				end else begin
					presc_cnt = presc_cnt + 1'b1;
				end
				// fire enabled pending channels, then re-arm or disable
				for (i = 0; i < NCH; i++) begin
					if (en_flag[i] && pend_flag[i]) begin
						fired[i]     = 1'b1;
						pend_flag[i] = 1'b0;
						if (rep_flag[i]) begin
							cmp_val[i]   = step_cnt + per_val[i];
							pend_flag[i] = (per_val[i] == '0);
						end else begin
							en_flag[i] = 1'b0;
						end
					end
				end
			end
			ACT_START: begin
				if (ch < NCH) begin
					ticks         = ms ? {dly[DelayW-3:0], 2'b00} : dly;
					per_val[ch]   = ticks + 1'b1;
					rep_flag[ch]  = rp;
					cmp_val[ch]   = step_cnt + per_val[ch];
					pend_flag[ch] = (per_val[ch] == '0);
					en_flag[ch]   = 1'b1;
				end
			end
			ACT_STOP: begin
				if (ch < NCH)
					en_flag[ch] = 1'b0;
			end
			default: ;
		endcase
		res.fire   = fired;
		res.active = MaskW'(en_flag);
		res.count  = CountOutW'(step_cnt);
		return res;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			n_fail++;
			if (n_fail <= REPORT_MAX)
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Watch both channels and the register port at each rising edge
	always @(posedge clk) begin : watch
		timer_result_t want;
		int            i;
		if (!arst_n) begin
			ratio_reg = RatioW'(1);
			presc_cnt = '0;
			step_cnt  = '0;
			rep_flag  = '0;
			en_flag   = '0;
			pend_flag = '0;
			for (i = 0; i < NCH; i++) begin
				cmp_val[i] = '0;
				per_val[i] = '0;
			end
			due_results.delete();
		end else begin
			if (cfg_wr_en)
				ratio_reg = cfg_wr_data;
			if (in_valid && in_ready)
				due_results.push_back(step_timer(action, channel, delay, in_ms, repeat_mode));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_MAX)
						$display("%0t ns: result with none expected, got fire %0h active %0h count %0d",
							$time, fire_mask, active_mask, count_now);
				end else begin
					want = due_results.pop_front();
					check_field("fire_mask", 32'(want.fire), 32'(fire_mask));
					check_field("active_mask", 32'(want.active), 32'(active_mask));
					check_field("count_now", 32'(want.count), 32'(count_now));
					n_checked++;
					if (want.fire != '0)
						n_fired++;
				end
			end
		end
		fail_cnt    <= n_fail;
		outstanding <= due_results.size();
		checked_cnt <= n_checked;
		fired_cnt   <= n_fired;
	end

endmodule

/* sim/tb.sv */
// Top of the compare timer testbench: clock, reset, prescale settings, timer operations
// and output back-pressure, with the verdict. Depends on mcct_pkg, timer_checker and the RTL.
`timescale 1ns / 100ps

module tb;
	import mcct_pkg::*;

	localparam logic [ActionW-1:0] ACT_UNKNOWN = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int NUM_PHASES = 11;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [RatioW-1:0]    cfg_wr_data = '0;
	logic                 in_valid    = 1'b0;
	logic [ActionW-1:0]   action      = '0;
	logic [ChannelW-1:0]  channel     = '0;
	logic [DelayW-1:0]    delay       = '0;
	logic                 in_ms       = 1'b0;
	logic                 repeat_mode = 1'b0;
	logic                 out_ready   = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic [MaskW-1:0]     fire_mask;
	logic [MaskW-1:0]     active_mask;
	logic [CountOutW-1:0] count_now;

	int fail_cnt;
	int outstanding;
	int checked_cnt;
	int fired_cnt;

	int n_sent   = 0;
	int tx_mode  = 1;
	int rx_mode  = 1;
	int rx_wait  = 0;
	int idle_cyc = 0;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	multi_channel_compare_timer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.channel     (channel),
		.delay       (delay),
		.in_ms       (in_ms),
		.repeat_mode (repeat_mode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fire_mask   (fire_mask),
		.active_mask (active_mask),
		.count_now   (count_now)
	);

	timer_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.channel     (channel),
		.delay       (delay),
		.in_ms       (in_ms),
		.repeat_mode (repeat_mode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fire_mask   (fire_mask),
		.active_mask (active_mask),
		.count_now   (count_now),
		.fail_cnt    (fail_cnt),
		.outstanding (outstanding),
		.checked_cnt (checked_cnt),
		.fired_cnt   (fired_cnt)
	);

	// Wait length per item: mode 0 never waits, 1 waits 0..12, 2 waits now and then
	function automatic int draw_wait(input int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(0, 12);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
		endcase
	endfunction

	// Receiver: stall a drawn number of cycles after each result transfer
	always @(posedge clk) begin : rx_side
		int w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
		end else if (out_valid && out_ready) begin
			if ($urandom_range(0, 49) == 0)
				rx_mode = $urandom_range(0, 2);
			w = draw_wait(rx_mode);
			rx_wait   <= w;
			out_ready <= (w == 0);
		end else if (rx_wait > 0) begin
			rx_wait   <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one timer operation after a drawn gap and hold it until the transfer
	task automatic send_item(input logic [ActionW-1:0] act, input logic [ChannelW-1:0] ch,
			input logic [DelayW-1:0] dly, input logic ms, input logic rp);
		int gap;
		gap = draw_wait(tx_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action      <= act;
		channel     <= ch;
		delay       <= dly;
		in_ms       <= ms;
		repeat_mode <= rp;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Mostly ticks, with starts of short periods so channels keep firing, plus stops and unknown actions
	task automatic send_random_item();
		int                  pick;
		logic                ms;
		logic [DelayW-1:0]   dly;
		pick = $urandom_range(0, 99);
		ms   = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 19))
			0:       dly = 16'hFFFF;
			1, 2:    dly = DelayW'($urandom_range(0, 65535));
			3:       dly = 16'(($urandom_range(0, 3) << 14)
					| ($urandom_range(0, 1) ? 16'h3FFF : 16'h0000));
			default: dly = ms ? DelayW'($urandom_range(0, 4)) : DelayW'($urandom_range(0, 24));
		endcase
		if (pick < 66)
			send_item(ACT_TICK, ChannelW'($urandom_range(0, 3)),
				DelayW'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		else if (pick < 84)
			send_item(ACT_START, ChannelW'($urandom_range(0, 3)), dly, ms,
				1'($urandom_range(0, 1)));
		else if (pick < 96)
			send_item(ACT_STOP, ChannelW'($urandom_range(0, 3)), dly, ms,
				1'($urandom_range(0, 1)));
		else
			send_item(ACT_UNKNOWN, ChannelW'($urandom_range(0, 3)), dly, ms,
				1'($urandom_range(0, 1)));
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_ratio(input logic [RatioW-1:0] ratio);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ratio;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin : stimulus
		logic [RatioW-1:0] ratio;
		int                n_items;
		int                p;
		int                k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_ratio(RatioW'(1));

		// Directed: short and wrapped periods, millisecond shifts, stop and unknown action
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_START, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_START, 2'd1, 16'hFFFF, 1'b0, 1'b1);
		send_item(ACT_TICK, 2'd3, 16'hFFFF, 1'b1, 1'b1);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_START, 2'd2, 16'hFFFF, 1'b1, 1'b0);
		send_item(ACT_START, 2'd3, 16'h4000, 1'b1, 1'b1);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_STOP, 2'd1, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_STOP, 2'd1, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_START, 2'd0, 16'h3FFF, 1'b1, 1'b0);
		send_item(ACT_UNKNOWN, 2'd3, 16'hFFFF, 1'b1, 1'b1);
		send_item(ACT_START, 2'd1, 16'h8000, 1'b0, 1'b1);
		send_item(ACT_STOP, 2'd3, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_START, 2'd3, 16'h0001, 1'b0, 1'b1);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_TICK, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_STOP, 2'd0, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_STOP, 2'd2, 16'h0000, 1'b0, 1'b0);
		send_item(ACT_TICK, 2'd3, 16'hFFFF, 1'b1, 1'b1);

		// Random phases, each under its own prescale ratio, including zero and saturation
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       ratio = RatioW'(0);
				1:       ratio = RatioW'(1);
				2:       ratio = RatioW'(2);
				3:       ratio = 17'h1FFFF;
				4:       ratio = RatioW'(3);
				5:       ratio = 17'h10000;
				6:       ratio = RatioW'(4);
				7:       ratio = RatioW'(100000);
				8:       ratio = RatioW'(1);
				9:       ratio = RatioW'(2);
				default: ratio = RatioW'($urandom_range(1, 6));
			endcase
			n_items = (ratio > 16) ? 80 : 210;
			drain();
			write_ratio(ratio);
			for (k = 0; k < n_items; k++) begin
				if (k % 50 == 0)
					tx_mode = $urandom_range(0, 2);
				send_random_item();
			end
		end

		// Let any stray result show up before the verdict
		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d timer operations across %0d prescale settings, ratio 0 to 131071.",
			n_sent, NUM_PHASES + 1);
		$display("Compared %0d results, %0d of them with at least one channel firing.",
			checked_cnt, fired_cnt);
		if (fail_cnt == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
